@@ rtl/u8cw_pkg.sv @@
// shared types and constants for the utf-8 decoder with column width
`timescale 1ns / 1ps
`default_nettype none

package u8cw_pkg;

  // lead byte thresholds and continuation byte pattern
  localparam logic [7:0] LEAD4_MIN    = 8'hF0;
  localparam logic [7:0] LEAD3_MIN    = 8'hE0;
  localparam logic [7:0] LEAD2_MIN    = 8'hC0;
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_TAG     = 8'h80;

  // sequence lengths as kept in the decoder
  localparam logic [2:0] SEQ_NONE     = 3'd0;
  localparam logic [2:0] SEQ_LEN1     = 3'd1;
  localparam logic [2:0] SEQ_LEN2     = 3'd2;
  localparam logic [2:0] SEQ_LEN3     = 3'd3;
  localparam logic [2:0] SEQ_LEN4     = 3'd4;

  // display widths
  localparam logic [1:0] COLS_NARROW  = 2'd1;
  localparam logic [1:0] COLS_WIDE    = 2'd2;

  // running column sum, saturating at all ones
  localparam int unsigned COL_SUM_BITS = 16;
  localparam int unsigned TOTAL_BITS   = 16;
  localparam logic [COL_SUM_BITS-1:0] COL_SUM_MAX = '1;

  // up to four results come out of one input byte
  localparam int unsigned MAX_RESULTS  = 4;
  localparam int unsigned CNT_BITS     = $clog2(MAX_RESULTS + 1);
  localparam int unsigned IDX_BITS     = $clog2(MAX_RESULTS);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [20:0]           code_point;
    logic [2:0]            byte_count;
    logic [1:0]            columns;
    logic [TOTAL_BITS-1:0] total_columns;
    logic                  run_end;
    logic                  text_end;
  } out_word_t;

  // one pending result before the column total is known
  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    logic [1:0]  columns;
  } res_ent_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [CNT_BITS-1:0]              cnt;
    logic                             eot;
    res_ent_t [MAX_RESULTS-1:0]       ent;
  } burst_t;

endpackage

`default_nettype wire

@@ rtl/u8cw_decode.sv @@
// sequence state and per-byte result list of the utf-8 decoder
`timescale 1ns / 1ps
`default_nettype none

module u8cw_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire u8cw_pkg::in_word_t in_word_i,
  output u8cw_pkg::burst_t       burst_o
);
  import u8cw_pkg::*;

  logic [7:0]  lead_q, lead_d;
  logic [2:0]  exp_q, exp_d;
  logic [7:0]  buf_q [2];
  logic [7:0]  buf_d [2];
  logic [1:0]  seen_q, seen_d;
  logic [20:0] part_q, part_d;

  // east asian, fullwidth and emoji ranges take two columns
  function automatic logic is_wide(input logic [20:0] v);
    logic w;
    w = (v >= 21'h01100 && v <= 21'h0115F) ||
        (v >= 21'h02E80 && v <= 21'h0A4CF) ||
        (v >= 21'h0AC00 && v <= 21'h0D7A3) ||
        (v >= 21'h0F900 && v <= 21'h0FAFF) ||
        (v >= 21'h0FE30 && v <= 21'h0FE6F) ||
        (v >= 21'h0FF00 && v <= 21'h0FF60) ||
        (v >= 21'h0FFE0 && v <= 21'h0FFE6) ||
        (v >= 21'h1F300 && v <= 21'h1F64F) ||
        (v >= 21'h1F900 && v <= 21'h1F9FF) ||
        (v >= 21'h20000 && v <= 21'h3FFFD);
    return w;
  endfunction

  // result list and next sequence state for the byte on the input
  always_comb begin
    logic [7:0]          b;
    logic                eot;
    logic                fresh;
    logic [20:0]         nv;
    logic [CNT_BITS-1:0] cnt;
    b       = in_word_i.in_byte;
    eot     = in_word_i.end_of_text;
    fresh   = 1'b1;
    nv      = {part_q[14:0], b[5:0]};
    cnt     = '0;
    lead_d  = lead_q;
    exp_d   = exp_q;
    buf_d   = buf_q;
    seen_d  = seen_q;
    part_d  = part_q;
    burst_o = '0;

    if (exp_q != SEQ_NONE) begin
      if ((b & CONT_MASK) == CONT_TAG) begin
        fresh  = 1'b0;
        part_d = nv;
        if (({1'b0, seen_q} + 3'd2) >= exp_q) begin
          // sequence complete
          burst_o.ent[cnt[IDX_BITS-1:0]].code_point = nv;
          burst_o.ent[cnt[IDX_BITS-1:0]].byte_count = exp_q;
          burst_o.ent[cnt[IDX_BITS-1:0]].columns    = is_wide(nv) ? COLS_WIDE : COLS_NARROW;
          cnt    = cnt + 1'b1;
          exp_d  = SEQ_NONE;
        end else begin
          buf_d[seen_q[0]] = b;
          seen_d = seen_q + 2'd1;
          if (eot) begin
            // text ends mid-sequence: lead and buffered bytes as singles
            burst_o.ent[cnt[IDX_BITS-1:0]] = '{{13'd0, lead_q}, SEQ_LEN1, COLS_NARROW};
            cnt = cnt + 1'b1;
            burst_o.ent[cnt[IDX_BITS-1:0]] = '{{13'd0, buf_d[0]}, SEQ_LEN1, COLS_NARROW};
            cnt = cnt + 1'b1;
            if (seen_d == 2'd2) begin
              burst_o.ent[cnt[IDX_BITS-1:0]] = '{{13'd0, buf_d[1]}, SEQ_LEN1, COLS_NARROW};
              cnt = cnt + 1'b1;
            end
          end
        end
      end else begin
        // broken sequence: replay lead and buffered bytes
        burst_o.ent[cnt[IDX_BITS-1:0]] = '{{13'd0, lead_q}, SEQ_LEN1, COLS_NARROW};
        cnt = cnt + 1'b1;
        if (seen_q >= 2'd1) begin
          burst_o.ent[cnt[IDX_BITS-1:0]] = '{{13'd0, buf_q[0]}, SEQ_LEN1, COLS_NARROW};
          cnt = cnt + 1'b1;
        end
        if (seen_q >= 2'd2) begin
          burst_o.ent[cnt[IDX_BITS-1:0]] = '{{13'd0, buf_q[1]}, SEQ_LEN1, COLS_NARROW};
          cnt = cnt + 1'b1;
        end
        exp_d = SEQ_NONE;
      end
    end

    // byte handled with no sequence open
    if (fresh) begin
      if (b >= LEAD2_MIN) begin
        lead_d = b;
        seen_d = '0;
        if (b >= LEAD4_MIN) begin
          exp_d  = SEQ_LEN4;
          part_d = {18'd0, b[2:0]};
        end else if (b >= LEAD3_MIN) begin
          exp_d  = SEQ_LEN3;
          part_d = {17'd0, b[3:0]};
        end else begin
          exp_d  = SEQ_LEN2;
          part_d = {16'd0, b[4:0]};
        end
        if (eot) begin
          burst_o.ent[cnt[IDX_BITS-1:0]] = '{{13'd0, b}, SEQ_LEN1, COLS_NARROW};
          cnt = cnt + 1'b1;
        end
      end else begin
        burst_o.ent[cnt[IDX_BITS-1:0]] = '{{13'd0, b}, SEQ_LEN1, COLS_NARROW};
        cnt = cnt + 1'b1;
      end
    end

    // a closed sequence or the end of the text leaves all state cleared
    if (eot || exp_d == SEQ_NONE) begin
      lead_d = '0;
      exp_d  = SEQ_NONE;
      buf_d  = '{default: '0};
      seen_d = '0;
      part_d = '0;
    end

    burst_o.cnt = cnt;
    burst_o.eot = eot;
  end

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      exp_q  <= SEQ_NONE;
      buf_q  <= '{default: '0};
      seen_q <= '0;
      part_q <= '0;
    end else if (accept_i) begin
      lead_q <= lead_d;
      exp_q  <= exp_d;
      buf_q  <= buf_d;
      seen_q <= seen_d;
      part_q <= part_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/utf8_decode_with_column_width_core.sv @@
// top level of the utf-8 decoder with display width and running column total
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte of utf-8 text per word on the input channel and gives one
// word per decoded code point with its value, byte count, display width and
// the running column total of the text. The decoder and its result list sit
// in front of a burst register that holds the results of one byte; a single
// output register drains that list one result per cycle while the output
// is not stalled. A byte that gives no result or one result does not hold
// the input, so plain text streams at one byte per cycle when the output
// does not stall; a byte that gives several results (a broken or cut-off
// sequence, up to four) holds the input until its last result moves to the
// output register. The column total saturates and starts again from zero
// after the word that ends the text.
module utf8_decode_with_column_width_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire u8cw_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output u8cw_pkg::out_word_t      out_word_o
);
  import u8cw_pkg::*;

  burst_t                     burst;
  logic                       accept;
  logic [CNT_BITS-1:0]        a_rem_q, a_rem_d;
  res_ent_t [MAX_RESULTS-1:0] a_ent_q, a_ent_d;
  logic                       a_eot_q;
  logic                       a_valid, a_move, a_last;
  logic                       b_valid_q, b_valid_d, b_free;
  out_word_t                  b_word_q, b_word_d;
  logic [COL_SUM_BITS-1:0]    sum_q, sum_d;
  logic [COL_SUM_BITS:0]      sum_add;
  logic [COL_SUM_BITS-1:0]    sum_sat;
  logic [COL_SUM_BITS+TOTAL_BITS-1:0] sum_ext;

  u8cw_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .burst_o   (burst)
  );

  // handshake between burst register and output register
  assign b_free     = !b_valid_q || !out_stall_i;
  assign a_valid    = (a_rem_q != '0);
  assign a_move     = a_valid && b_free;
  assign a_last     = a_move && (a_rem_q == CNT_BITS'(1));
  assign in_stall_o = a_valid && !a_last;
  assign accept     = in_valid_i && !in_stall_o;

  // burst register load and shift
  always_comb begin
    a_rem_d = a_rem_q;
    a_ent_d = a_ent_q;
    if (accept) begin
      a_rem_d = burst.cnt;
      a_ent_d = burst.ent;
    end else if (a_move) begin
      a_rem_d = a_rem_q - 1'b1;
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        a_ent_d[i] = a_ent_q[i+1];
      end
    end
  end

  // saturating column total for the result that moves out
  assign sum_add = {1'b0, sum_q} + {{(COL_SUM_BITS-1){1'b0}}, a_ent_q[0].columns};
  assign sum_sat = sum_add[COL_SUM_BITS] ? COL_SUM_MAX : sum_add[COL_SUM_BITS-1:0];
  assign sum_ext = {{TOTAL_BITS{1'b0}}, sum_sat};

  // output register next state
  always_comb begin
    b_valid_d = b_valid_q;
    b_word_d  = b_word_q;
    sum_d     = sum_q;
    if (a_move) begin
      b_valid_d              = 1'b1;
      b_word_d.code_point    = a_ent_q[0].code_point;
      b_word_d.byte_count    = a_ent_q[0].byte_count;
      b_word_d.columns       = a_ent_q[0].columns;
      b_word_d.total_columns = sum_ext[TOTAL_BITS-1:0];
      b_word_d.run_end       = (a_rem_q == CNT_BITS'(1));
      b_word_d.text_end      = (a_rem_q == CNT_BITS'(1)) && a_eot_q;
      sum_d                  = b_word_d.text_end ? '0 : sum_sat;
    end else if (!out_stall_i) begin
      b_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rem_q   <= '0;
      b_valid_q <= 1'b0;
      sum_q     <= '0;
    end else begin
      a_rem_q   <= a_rem_d;
      b_valid_q <= b_valid_d;
      sum_q     <= sum_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a_ent_q  <= a_ent_d;
    b_word_q <= b_word_d;
    if (accept) begin
      a_eot_q <= burst.eot;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_word_o  = b_word_q;

endmodule

`default_nettype wire

@@ rtl/u8cw_checker.sv @@
// port checks for the utf-8 decoder with column width, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module u8cw_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire u8cw_pkg::out_word_t out_word_o
);
  import u8cw_pkg::*;

  // no word is offered while in reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled output word changed");

  // the end of a text is also the end of its byte's run
  a_text_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.text_end) |-> out_word_o.run_end)
    else $error("text end without run end");

  // single bytes are narrow and fit in a byte
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.byte_count == SEQ_LEN1) |->
      (out_word_o.code_point[20:8] == '0 && out_word_o.columns == COLS_NARROW))
    else $error("single byte result is wide or out of range");

  // further results of the same byte follow without a gap
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_word_o.run_end) |=> out_valid_o)
    else $error("gap inside a run of results");

endmodule

bind utf8_decode_with_column_width_core u8cw_checker u_checker (.*);

`default_nettype wire
